// ===== hdl/polynomial_arccos_approx_assert.svh =====
// Assertion macros shared by the checker.
`ifndef POLYNOMIAL_ARCCOS_APPROX_ASSERT_SVH
`define POLYNOMIAL_ARCCOS_APPROX_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define PACOS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pacos: implication failed");

// Next-cycle implication, held off during reset.
`define PACOS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pacos: next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define PACOS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pacos: reset implication failed");

`endif

// ===== hdl/pacos_pkg.sv =====
`default_nettype none

package pacos_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 18;
  localparam int OUT_W         = 18;
  localparam int HORNER_STEPS  = 3;

  localparam logic [63:0] DEC_DEN = 64'd1000000000000000000;

  // Decimal magnitudes scaled by 1e18.
  localparam logic [63:0] NUM_A3 = 64'd20873044290785601;
  localparam logic [63:0] NUM_A2 = 64'd76876940416167189;
  localparam logic [63:0] NUM_A1 = 64'd212871094165645952;
  localparam logic [63:0] NUM_A0 = 64'd1570758353652096590;
  localparam logic [63:0] NUM_PI = 64'd3141592653589793238;

  typedef struct packed {
    logic neg;
    logic derr;
  } pacos_flags_t;

  // Round a decimal constant to frac fraction bits, ties away from zero.
  function automatic logic signed [63:0] round_const(input logic [63:0] num,
                                                     input logic neg,
                                                     input int frac);
    logic [63:0] r;
    logic [63:0] acc;
    r   = num % DEC_DEN;
    acc = num / DEC_DEN;
    for (int i = 0; i <= frac; i++) begin
      r   = r << 1;
      acc = acc << 1;
      if (r >= DEC_DEN) begin
        acc = acc | 64'd1;
        r   = r - DEC_DEN;
      end
    end
    acc = (acc + 64'd1) >> 1;
    return neg ? -$signed(acc) : $signed(acc);
  endfunction

  // Coefficient added after Horner step idx.
  function automatic logic signed [63:0] horner_coef(input int idx, input int frac);
    logic signed [63:0] c;
    case (idx)
      0:       c = round_const(NUM_A2, 1'b0, frac);
      1:       c = round_const(NUM_A1, 1'b1, frac);
      default: c = round_const(NUM_A0, 1'b0, frac);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pacos_front.sv =====
`default_nettype none

module pacos_front #(
  parameter int FRAC_BITS = pacos_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [pacos_pkg::IN_W-1:0] in_cos,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output pacos_pkg::pacos_flags_t                out_flags,
  output logic [FRAC_BITS:0]                     out_mag,
  output logic [2*FRAC_BITS+1:0]                 out_rem
);
  import pacos_pkg::*;

  localparam int CW = (FRAC_BITS + 2 > IN_W + 1) ? FRAC_BITS + 2 : IN_W + 1;
  localparam int RW = 2 * FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] ONE    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CW-1:0]      ONE_CW = CW'(ONE);
  localparam logic [CW-1:0]      WRAP   = CW'(1) << IN_W;

  logic                  valid;
  pacos_flags_t          flags;
  logic [FRAC_BITS:0]    mag;
  logic [RW-1:0]         rem;

  logic                  neg_next;
  logic [CW-1:0]         raw_u;
  logic [CW-1:0]         mag_ext;
  logic                  over;
  logic [FRAC_BITS:0]    mag_next;
  logic [RW-1:0]         rem_next;

  always_comb begin
    neg_next = in_cos[IN_W-1];
    raw_u    = CW'({1'b0, in_cos});
    mag_ext  = neg_next ? (WRAP - raw_u) : raw_u;
    over     = mag_ext > ONE_CW;
    mag_next = over ? ONE : mag_ext[FRAC_BITS:0];
    rem_next = RW'(ONE - mag_next) << FRAC_BITS;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_flags = flags;
  assign out_mag   = mag;
  assign out_rem   = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      flags.neg  <= neg_next;
      flags.derr <= over;
      mag        <= mag_next;
      rem        <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pacos_stage.sv =====
`default_nettype none

// One root bit per stage; the first stages also run one Horner step.
module pacos_stage #(
  parameter int FRAC_BITS = pacos_pkg::FRAC_BITS_DEF,
  parameter int IDX       = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire pacos_pkg::pacos_flags_t       in_flags,
  input  wire logic [FRAC_BITS:0]            in_mag,
  input  wire logic signed [FRAC_BITS+2:0]   in_p,
  input  wire logic [2*FRAC_BITS+1:0]        in_rem,
  input  wire logic [FRAC_BITS:0]            in_root,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pacos_pkg::pacos_flags_t            out_flags,
  output logic [FRAC_BITS:0]                 out_mag,
  output logic signed [FRAC_BITS+2:0]        out_p,
  output logic [2*FRAC_BITS+1:0]             out_rem,
  output logic [FRAC_BITS:0]                 out_root
);
  import pacos_pkg::*;

  localparam int PW = FRAC_BITS + 3;
  localparam int RW = 2 * FRAC_BITS + 2;
  localparam int NB = FRAC_BITS + 1;
  localparam int BI = NB - 1 - IDX;

  logic                  valid;
  pacos_flags_t          flags;
  logic [FRAC_BITS:0]    mag;
  logic signed [PW-1:0]  p;
  logic [RW-1:0]         rem;
  logic [FRAC_BITS:0]    root;

  logic signed [PW-1:0]  p_next;
  logic [RW-1:0]         trial;
  logic                  take;
  logic [RW-1:0]         rem_next;
  logic [FRAC_BITS:0]    root_next;

  if (IDX < HORNER_STEPS) begin : g_horner
    localparam logic signed [PW-1:0] COEF = PW'(horner_coef(IDX, FRAC_BITS));
    logic signed [PW+FRAC_BITS+1:0] prod;
    logic signed [PW+FRAC_BITS+1:0] prod_sh;
    always_comb begin
      prod    = in_p * $signed({1'b0, in_mag});
      prod_sh = prod >>> FRAC_BITS;
      p_next  = PW'(prod_sh) + COEF;
    end
  end else begin : g_pass
    assign p_next = in_p;
  end

  always_comb begin
    trial     = (RW'(in_root) << (BI + 1)) + (RW'(1) << (2 * BI));
    take      = in_rem >= trial;
    rem_next  = take ? (in_rem - trial) : in_rem;
    root_next = take ? (in_root | (NB'(1) << BI)) : in_root;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_flags = flags;
  assign out_mag   = mag;
  assign out_p     = p;
  assign out_rem   = rem;
  assign out_root  = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      flags <= in_flags;
      mag   <= in_mag;
      p     <= p_next;
      rem   <= rem_next;
      root  <= root_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pacos_back.sv =====
`default_nettype none

// Product with the root, then reflection about pi for negative inputs.
module pacos_back #(
  parameter int FRAC_BITS = pacos_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire pacos_pkg::pacos_flags_t      in_flags,
  input  wire logic signed [FRAC_BITS+2:0]  in_p,
  input  wire logic [FRAC_BITS:0]           in_root,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [pacos_pkg::OUT_W-1:0]       out_angle,
  output logic                              out_derr
);
  import pacos_pkg::*;

  localparam int PW  = FRAC_BITS + 3;
  localparam int AGW = FRAC_BITS + 3;
  localparam int XW  = (FRAC_BITS + 4 > OUT_W + 1) ? FRAC_BITS + 4 : OUT_W + 1;
  localparam logic signed [XW-1:0] PI = XW'(round_const(NUM_PI, 1'b0, FRAC_BITS));

  logic                  m_valid;
  pacos_flags_t          m_flags;
  logic signed [AGW-1:0] m_ang;
  logic                  m_ready;

  logic                  o_valid;
  logic [OUT_W-1:0]      o_angle;
  logic                  o_derr;
  logic                  o_ready;

  logic signed [PW+FRAC_BITS+1:0] prod;
  logic signed [PW+FRAC_BITS+1:0] prod_sh;
  logic signed [AGW-1:0]          ang_next;
  logic signed [XW-1:0]           ang_x;
  logic signed [XW-1:0]           diff;
  logic signed [XW-1:0]           res;

  always_comb begin
    prod     = in_p * $signed({1'b0, in_root});
    prod_sh  = prod >>> FRAC_BITS;
    ang_next = AGW'(prod_sh);
  end

  always_comb begin
    ang_x = XW'(m_ang);
    diff  = m_flags.neg ? (PI - ang_x) : ang_x;
    res   = diff[XW-1] ? '0 : diff;
  end

  assign o_ready   = !o_valid || !out_stall;
  assign m_ready   = !m_valid || o_ready;
  assign in_ready  = m_ready;
  assign out_valid = o_valid;
  assign out_angle = o_angle;
  assign out_derr  = o_derr;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid <= in_valid;
      end
      if (o_ready) begin
        o_valid <= m_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && m_ready) begin
      m_flags <= in_flags;
      m_ang   <= ang_next;
    end
    if (m_valid && o_ready) begin
      o_angle <= res[OUT_W-1:0];
      o_derr  <= m_flags.derr;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/polynomial_arccos_approx.sv =====
// Channel  Handshake             Payload
// input    in_valid / in_stall   cos_value  (18b signed, FRAC_BITS fraction bits)
// output   out_valid / out_stall angle (18b unsigned), domain_error (1b)
//
// One word per cycle sustained while out_stall is low.
// Latency is set by the square root, one result bit per stage (FRAC_BITS + 1
// stages); the cubic runs alongside in the first three of them.
// rst is synchronous and clears only the valid bits.
// Each stage holds while its successor is full and stalled; bubbles collapse.
`default_nettype none

module polynomial_arccos_approx #(
  parameter int FRAC_BITS = pacos_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [pacos_pkg::IN_W-1:0] cos_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [pacos_pkg::OUT_W-1:0]            angle,
  output logic                                   domain_error
);
  import pacos_pkg::*;

  localparam int PW = FRAC_BITS + 3;
  localparam int RW = 2 * FRAC_BITS + 2;
  localparam int NB = FRAC_BITS + 1;
  localparam logic signed [PW-1:0] A3 = PW'(round_const(NUM_A3, 1'b1, FRAC_BITS));

  logic                  valid_s [0:NB];
  logic                  ready_s [0:NB];
  pacos_flags_t          flags_s [0:NB];
  logic [FRAC_BITS:0]    mag_s   [0:NB];
  logic signed [PW-1:0]  p_s     [0:NB];
  logic [RW-1:0]         rem_s   [0:NB];
  logic [FRAC_BITS:0]    root_s  [0:NB];
  logic                  front_ready;

  assign in_stall  = !front_ready;
  assign p_s[0]    = A3;
  assign root_s[0] = '0;

  pacos_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .in_cos    (cos_value),
    .out_valid (valid_s[0]),
    .out_ready (ready_s[0]),
    .out_flags (flags_s[0]),
    .out_mag   (mag_s[0]),
    .out_rem   (rem_s[0])
  );

  for (genvar k = 0; k < NB; k++) begin : g_stage
    pacos_stage #(.FRAC_BITS(FRAC_BITS), .IDX(k)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_s[k]),
      .in_ready  (ready_s[k]),
      .in_flags  (flags_s[k]),
      .in_mag    (mag_s[k]),
      .in_p      (p_s[k]),
      .in_rem    (rem_s[k]),
      .in_root   (root_s[k]),
      .out_valid (valid_s[k+1]),
      .out_ready (ready_s[k+1]),
      .out_flags (flags_s[k+1]),
      .out_mag   (mag_s[k+1]),
      .out_p     (p_s[k+1]),
      .out_rem   (rem_s[k+1]),
      .out_root  (root_s[k+1])
    );
  end

  pacos_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_s[NB]),
    .in_ready  (ready_s[NB]),
    .in_flags  (flags_s[NB]),
    .in_p      (p_s[NB]),
    .in_root   (root_s[NB]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_angle (angle),
    .out_derr  (domain_error)
  );

endmodule

`default_nettype wire

// ===== hdl/pacos_checker.sv =====
`default_nettype none
`include "polynomial_arccos_approx_assert.svh"

module pacos_checker #(
  parameter int FRAC_BITS = pacos_pkg::FRAC_BITS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [pacos_pkg::OUT_W-1:0]  angle,
  input wire logic                         domain_error
);
  import pacos_pkg::*;

  localparam logic [OUT_W-1:0] PI_OUT = OUT_W'(round_const(NUM_PI, 1'b0, FRAC_BITS));

  logic out_free;
  logic derr_word;
  logic held_word;

  assign out_free  = !out_valid || !out_stall;
  assign derr_word = out_valid && domain_error;
  assign held_word = out_valid && out_stall;

  // A free output end frees every stage down to the input.
  `PACOS_ASSERT_IMPL(a_no_stall_when_drained, clk, rst, out_free, !in_stall)

  // A clamped input lands exactly on zero or pi.
  `PACOS_ASSERT_IMPL(a_clamp_angle, clk, rst, derr_word,
                     (angle == '0) || (angle == PI_OUT))

  `PACOS_ASSERT_NEXT(a_hold_stalled, clk, rst, held_word,
                     out_valid && $stable(angle) && $stable(domain_error))

  // Nothing leaves the pipe right after reset.
  `PACOS_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind polynomial_arccos_approx pacos_checker #(.FRAC_BITS(FRAC_BITS)) u_pacos_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .angle        (angle),
  .domain_error (domain_error)
);

`default_nettype wire
